/* rtl/sge_pkg.sv */
`default_nettype none

package sge_pkg;

    localparam int INDEX_BITS = 24;
    localparam int WEIGHT_BITS = 32;

    typedef logic [INDEX_BITS-1:0] node_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;

    typedef enum logic [1:0] {
        RES_DOMINANT = 2'd0,
        RES_FIRST    = 2'd1,
        RES_SECOND   = 2'd2
    } res_idx_t;

    typedef struct packed {
        node_t    src;
        node_t    tgt_rev;
        node_t    tgt_prev;
        node_t    tgt_next;
        res_idx_t last_idx;
        logic     bad;
    } plan_t;

    localparam weight_t UNIT_WEIGHT = weight_t'(1);
    localparam weight_t WEIGHT_RESET = '1;

endpackage

`default_nettype wire

/* rtl/sge_decode.sv */
`default_nettype none

module sge_decode (
    input  wire sge_pkg::node_t edge_index,
    input  wire sge_pkg::node_t edge_position,
    input  wire sge_pkg::node_t vertex_degree,
    input  wire sge_pkg::node_t reverse_edge,
    output sge_pkg::plan_t      plan
);

    sge_pkg::node_t deg_m1;
    logic           bad;
    logic           pos_first;
    logic           pos_last;

    always_comb begin
        deg_m1    = vertex_degree - sge_pkg::node_t'(1);
        bad       = (edge_position >= vertex_degree);
        pos_first = (edge_position == '0);
        pos_last  = (edge_position == deg_m1);

        plan.src     = edge_index;
        plan.tgt_rev = reverse_edge;
        plan.bad     = bad;
        // previous node of the cycle, also the sibling for degree two
        plan.tgt_prev = pos_first ? (edge_index + deg_m1)
                                  : (edge_index - sge_pkg::node_t'(1));
        plan.tgt_next = pos_last ? (edge_index - deg_m1)
                                 : (edge_index + sge_pkg::node_t'(1));

        priority if (bad || vertex_degree == sge_pkg::node_t'(1)) begin
            plan.last_idx = sge_pkg::RES_DOMINANT;
        end else if (vertex_degree == sge_pkg::node_t'(2)) begin
            plan.last_idx = sge_pkg::RES_FIRST;
        end else begin
            plan.last_idx = sge_pkg::RES_SECOND;
        end
    end

endmodule

`default_nettype wire

/* rtl/split_graph_edge_generator.sv */
// an item waits in the plan register; each of its results is then registered
// an item gives 1, 2 or 3 results, one per cycle while m_ready stays high,
//   sent by the single result register
// a new item is taken while the previous one's last result is loaded
// reset (aresetn low, synchronous): channels empty, dominant weight all ones
`default_nettype none

module split_graph_edge_generator (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire sge_pkg::weight_t cfg_wdata,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire sge_pkg::node_t   s_edge_index,
    input  wire sge_pkg::node_t   s_edge_position,
    input  wire sge_pkg::node_t   s_vertex_degree,
    input  wire sge_pkg::node_t   s_reverse_edge,
    output logic                  m_valid,
    input  wire                   m_ready,
    output sge_pkg::node_t        m_split_source,
    output sge_pkg::node_t        m_split_target,
    output sge_pkg::weight_t      m_edge_weight,
    output logic                  m_last_of_run,
    output logic                  m_bad_position
);

    sge_pkg::weight_t  weight_reg;
    sge_pkg::plan_t    plan_next;
    sge_pkg::plan_t    plan_reg;
    logic              hold_valid_reg;
    sge_pkg::res_idx_t idx_reg;
    logic              out_valid_reg;
    sge_pkg::node_t    src_reg;
    sge_pkg::node_t    tgt_reg;
    sge_pkg::weight_t  wgt_reg;
    logic              last_reg;
    logic              bad_reg;

    logic              load;
    logic              is_last;
    sge_pkg::node_t    tgt_next;
    sge_pkg::weight_t  wgt_next;

    sge_decode u_decode (
        .edge_index    (s_edge_index),
        .edge_position (s_edge_position),
        .vertex_degree (s_vertex_degree),
        .reverse_edge  (s_reverse_edge),
        .plan          (plan_next)
    );

    always_comb begin
        load    = hold_valid_reg && (!out_valid_reg || m_ready);
        is_last = (idx_reg == plan_reg.last_idx);
        s_ready = !hold_valid_reg || (load && is_last);
        unique case (idx_reg)
            sge_pkg::RES_DOMINANT: begin
                tgt_next = plan_reg.tgt_rev;
                wgt_next = weight_reg;
            end
            sge_pkg::RES_FIRST: begin
                tgt_next = plan_reg.tgt_prev;
                wgt_next = sge_pkg::UNIT_WEIGHT;
            end
            sge_pkg::RES_SECOND: begin
                tgt_next = plan_reg.tgt_next;
                wgt_next = sge_pkg::UNIT_WEIGHT;
            end
            default: begin
                tgt_next = plan_reg.tgt_rev;
                wgt_next = weight_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg     <= sge_pkg::WEIGHT_RESET;
            hold_valid_reg <= 1'b0;
            idx_reg        <= sge_pkg::RES_DOMINANT;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                weight_reg <= cfg_wdata;
            end
            if (s_valid && s_ready) begin
                hold_valid_reg <= 1'b1;
                plan_reg       <= plan_next;
            end else if (load && is_last) begin
                hold_valid_reg <= 1'b0;
            end
            if (load) begin
                idx_reg <= is_last ? sge_pkg::RES_DOMINANT
                                   : sge_pkg::res_idx_t'(idx_reg + 2'd1);
            end
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            src_reg  <= plan_reg.src;
            tgt_reg  <= tgt_next;
            wgt_reg  <= wgt_next;
            last_reg <= is_last;
            bad_reg  <= plan_reg.bad && (idx_reg == sge_pkg::RES_DOMINANT);
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_split_source = src_reg;
    assign m_split_target = tgt_reg;
    assign m_edge_weight  = wgt_reg;
    assign m_last_of_run  = last_reg;
    assign m_bad_position = bad_reg;

endmodule

`default_nettype wire

/* rtl/sge_checker.sv */
`default_nettype none

module sge_checker (
    input wire                   aclk,
    input wire                   aresetn,
    input wire                   m_valid,
    input wire                   m_ready,
    input wire sge_pkg::node_t   m_split_source,
    input wire sge_pkg::node_t   m_split_target,
    input wire sge_pkg::weight_t m_edge_weight,
    input wire                   m_last_of_run,
    input wire                   m_bad_position
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_split_source)
            && $stable(m_split_target) && $stable(m_edge_weight)
            && $stable(m_last_of_run) && $stable(m_bad_position))
        else $error("stalled result changed");

    // a bad item gives a single result
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_position |-> m_last_of_run)
        else $error("bad item result not last");

    // the rest of a run follows at once from the same node with unit weight
    a_run_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid
            && m_split_source == $past(m_split_source)
            && m_edge_weight == sge_pkg::UNIT_WEIGHT && !m_bad_position)
        else $error("run broken");

endmodule

bind split_graph_edge_generator sge_checker u_sge_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_split_source (m_split_source),
    .m_split_target (m_split_target),
    .m_edge_weight  (m_edge_weight),
    .m_last_of_run  (m_last_of_run),
    .m_bad_position (m_bad_position)
);

`default_nettype wire

/* dv/split_graph_edge_generator_tb.sv */
`timescale 1ns / 1ps

module split_graph_edge_generator_tb;

    typedef struct packed {
        sge_pkg::node_t   src;
        sge_pkg::node_t   tgt;
        sge_pkg::weight_t weight;
        logic             last;
        logic             bad;
    } split_edge_t;

    typedef struct packed {
        sge_pkg::node_t idx;
        sge_pkg::node_t pos;
        sge_pkg::node_t deg;
        sge_pkg::node_t rev;
    } graph_edge_t;

    typedef struct packed {
        graph_edge_t e;
        logic        typed;
        logic        bad;
    } edge_row_t;

    localparam sge_pkg::node_t NODE_MAX = '1;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    sge_pkg::weight_t cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    sge_pkg::node_t   s_edge_index = '0;
    sge_pkg::node_t   s_edge_position = '0;
    sge_pkg::node_t   s_vertex_degree = '0;
    sge_pkg::node_t   s_reverse_edge = '0;
    logic             m_valid;
    logic             m_ready;
    sge_pkg::node_t   m_split_source;
    sge_pkg::node_t   m_split_target;
    sge_pkg::weight_t m_edge_weight;
    logic             m_last_of_run;
    logic             m_bad_position;

    split_edge_t      expected_edges[$];
    sge_pkg::weight_t dom_weight = sge_pkg::WEIGHT_RESET;
    bit               src_idle_on = 1'b1;
    bit               sink_idle_on = 1'b1;
    bit               sink_hold_req = 1'b0;
    int               n_fail = 0;
    int               n_items = 0;
    int               n_bad_items = 0;
    int               n_results = 0;
    int               n_weights = 1;

    // bad and degree-one rows carry their single expected edge inline
    edge_row_t dir_rows [16] = '{
        '{'{24'h000000, 24'h000000, 24'h000000, 24'h000000}, 1'b1, 1'b1},
        '{'{NODE_MAX,   NODE_MAX,   NODE_MAX,   NODE_MAX},   1'b1, 1'b1},
        '{'{24'h000005, 24'h000005, 24'h000005, 24'h000009}, 1'b1, 1'b1},
        '{'{24'h123456, NODE_MAX,   24'h000003, 24'habcdef}, 1'b1, 1'b1},
        '{'{24'h000000, 24'h000001, 24'h000001, NODE_MAX},   1'b1, 1'b1},
        '{'{NODE_MAX,   24'h000000, 24'h000001, 24'h000000}, 1'b1, 1'b0},
        '{'{24'h000000, 24'h000000, 24'h000001, NODE_MAX},   1'b1, 1'b0},
        '{'{24'h000000, 24'h000000, 24'h000002, 24'h000001}, 1'b0, 1'b0},
        '{'{24'h000000, 24'h000001, 24'h000002, NODE_MAX},   1'b0, 1'b0},
        '{'{NODE_MAX,   24'h000000, 24'h000002, 24'h000000}, 1'b0, 1'b0},
        '{'{24'h000000, 24'h000000, 24'h000003, 24'h000005}, 1'b0, 1'b0},
        '{'{24'h000000, 24'h000002, 24'h000003, 24'h000007}, 1'b0, 1'b0},
        '{'{24'h000005, 24'h000000, NODE_MAX,   24'h000002}, 1'b0, 1'b0},
        '{'{NODE_MAX,   24'hfffffe, NODE_MAX,   24'h000000}, 1'b0, 1'b0},
        '{'{24'h000007, 24'h000001, 24'h000003, 24'h000008}, 1'b0, 1'b0},
        '{'{24'h800000, 24'h7fffff, 24'h800000, 24'h3fffff}, 1'b0, 1'b0}
    };

    split_graph_edge_generator i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_edge_index    (s_edge_index),
        .s_edge_position (s_edge_position),
        .s_vertex_degree (s_vertex_degree),
        .s_reverse_edge  (s_reverse_edge),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_split_source  (m_split_source),
        .m_split_target  (m_split_target),
        .m_edge_weight   (m_edge_weight),
        .m_last_of_run   (m_last_of_run),
        .m_bad_position  (m_bad_position)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic void push_split_edge(sge_pkg::node_t src, sge_pkg::node_t tgt,
                                            sge_pkg::weight_t w, logic last, logic bad);
        split_edge_t x;
        x = '{src: src, tgt: tgt, weight: w, last: last, bad: bad};
        expected_edges.push_back(x);
    endfunction

    function automatic void predict_split_edges(graph_edge_t e);
        sge_pkg::node_t sib_node;
        sge_pkg::node_t prev_node;
        sge_pkg::node_t next_node;
        if (e.deg == '0 || e.pos >= e.deg) begin
            push_split_edge(e.idx, e.rev, dom_weight, 1'b1, 1'b1);
            return;
        end
        if (e.deg == sge_pkg::node_t'(1)) begin
            push_split_edge(e.idx, e.rev, dom_weight, 1'b1, 1'b0);
            return;
        end
        push_split_edge(e.idx, e.rev, dom_weight, 1'b0, 1'b0);
        if (e.deg == sge_pkg::node_t'(2)) begin
            sib_node = (e.pos == '0) ? e.idx + sge_pkg::node_t'(1)
                                     : e.idx - sge_pkg::node_t'(1);
            push_split_edge(e.idx, sib_node, sge_pkg::UNIT_WEIGHT, 1'b1, 1'b0);
            return;
        end
        prev_node = (e.pos == '0) ? e.idx + (e.deg - sge_pkg::node_t'(1))
                                  : e.idx - sge_pkg::node_t'(1);
        next_node = (e.pos == e.deg - sge_pkg::node_t'(1))
                    ? e.idx - (e.deg - sge_pkg::node_t'(1))
                    : e.idx + sge_pkg::node_t'(1);
        push_split_edge(e.idx, prev_node, sge_pkg::UNIT_WEIGHT, 1'b0, 1'b0);
        push_split_edge(e.idx, next_node, sge_pkg::UNIT_WEIGHT, 1'b1, 1'b0);
    endfunction

    function automatic graph_edge_t random_edge();
        graph_edge_t e;
        int unsigned pick;
        e.idx = sge_pkg::node_t'($urandom);
        e.rev = sge_pkg::node_t'($urandom);
        if ($urandom_range(99) < 8) e.idx = $urandom_range(1) ? '0 : NODE_MAX;
        pick = $urandom_range(99);
        if (pick < 60) e.deg = sge_pkg::node_t'($urandom_range(1, 6));
        else if (pick < 72) e.deg = sge_pkg::node_t'($urandom);
        else if (pick < 78) e.deg = NODE_MAX;
        else if (pick < 84) e.deg = '0;
        else e.deg = sge_pkg::node_t'($urandom_range(7, 40));
        if (e.deg != '0 && $urandom_range(99) < 85) begin
            pick = $urandom_range(2);
            if (pick == 0) e.pos = '0;
            else if (pick == 1) e.pos = e.deg - sge_pkg::node_t'(1);
            else e.pos = sge_pkg::node_t'($urandom) % e.deg;
        end else if (e.deg == NODE_MAX) begin
            e.pos = NODE_MAX;
        end else if ($urandom_range(1)) begin
            e.pos = e.deg + sge_pkg::node_t'($urandom_range(2));
        end else begin
            e.pos = sge_pkg::node_t'($urandom);
        end
        return e;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_edge(graph_edge_t e, logic typed, logic typed_bad);
        while (src_idle_on && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_edge_index    <= e.idx;
        s_edge_position <= e.pos;
        s_vertex_degree <= e.deg;
        s_reverse_edge  <= e.rev;
        do @(posedge aclk); while (!s_ready);
        if (typed) push_split_edge(e.idx, e.rev, sge_pkg::WEIGHT_RESET, 1'b1, typed_bad);
        else predict_split_edges(e);
        n_items++;
        if (e.deg == '0 || e.pos >= e.deg) n_bad_items++;
        @(negedge aclk);
    endtask

    task automatic send_random(int count);
        repeat (count) send_edge(random_edge(), 1'b0, 1'b0);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_edges.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_dominant_weight(sge_pkg::weight_t w);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        dom_weight = w;
        n_weights++;
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (60) @(negedge aclk);
            end
            m_ready <= !(sink_idle_on && $urandom_range(99) < 18);
        end
    end

    task automatic report_edge_error(bit have_exp, split_edge_t exp_e, split_edge_t got_e);
        n_fail++;
        if (n_fail <= 10) begin
            if (!have_exp)
                $display("unexpected split edge: src %h tgt %h w %h last %b bad %b",
                         got_e.src, got_e.tgt, got_e.weight, got_e.last, got_e.bad);
            else
                $display({"split edge mismatch: exp src %h tgt %h w %h last %b bad %b,",
                          " got src %h tgt %h w %h last %b bad %b"},
                         exp_e.src, exp_e.tgt, exp_e.weight, exp_e.last, exp_e.bad,
                         got_e.src, got_e.tgt, got_e.weight, got_e.last, got_e.bad);
        end
    endtask

    always @(posedge aclk) begin
        split_edge_t got_e;
        split_edge_t exp_e;
        if (aresetn && m_valid && m_ready) begin
            got_e = '{src: m_split_source, tgt: m_split_target, weight: m_edge_weight,
                      last: m_last_of_run, bad: m_bad_position};
            n_results++;
            if (expected_edges.size() == 0) begin
                report_edge_error(1'b0, got_e, got_e);
            end else begin
                exp_e = expected_edges.pop_front();
                if (got_e.src !== exp_e.src || got_e.tgt !== exp_e.tgt ||
                    got_e.weight !== exp_e.weight || got_e.last !== exp_e.last ||
                    got_e.bad !== exp_e.bad)
                    report_edge_error(1'b1, exp_e, got_e);
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) send_edge(dir_rows[i].e, dir_rows[i].typed, dir_rows[i].bad);

        set_dominant_weight('0);
        send_random(60);

        // long stretch with no idling on either side
        set_dominant_weight(sge_pkg::UNIT_WEIGHT);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random(60);

        // receiver holds off while items keep coming, then sender waits for drain
        sink_hold_req = 1'b1;
        send_random(30);
        drain_results();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        set_dominant_weight(sge_pkg::weight_t'($urandom));
        send_random(80);
        set_dominant_weight(sge_pkg::WEIGHT_RESET);
        send_random(60);
        set_dominant_weight(32'h8000_0000);
        send_random(70);

        drain_results();
        repeat (10) @(negedge aclk);

        $display("covered %0d edges (%0d with bad position or zero degree) under %0d weights",
                 n_items, n_bad_items, n_weights);
        $display("checked %0d split edges, %0d mismatches", n_results, n_fail);
        if (n_fail == 0 && expected_edges.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
